FILE: hdl/gvsp_packet_frame_tracker_core_assert.svh
// Assertion macros for the tracker modules, included by the back end.
`ifndef GVSP_PACKET_FRAME_TRACKER_CORE_ASSERT_SVH
`define GVSP_PACKET_FRAME_TRACKER_CORE_ASSERT_SVH

// The expression must hold at every clock edge outside reset.
`define GVSPFT_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define GVSPFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/gvspft_pkg.sv
package gvspft_pkg;

  localparam int FRAME_STORE_BYTES_DEF = 4194304;
  localparam int MAX_PACKET_BYTES_DEF  = 1536;

  localparam logic [10:0] NOMINAL_RESET = 11'd1480;

  localparam logic [6:0] KIND_LEADER    = 7'd1;
  localparam logic [6:0] KIND_TRAILER   = 7'd2;
  localparam logic [6:0] KIND_PAYLOAD   = 7'd3;
  localparam logic [6:0] KIND_MULTIPART = 7'd7;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Classified packet handed from the front part to the back part.
  typedef struct packed {
    logic [6:0]  kind;
    logic [31:0] pid;
    logic [63:0] fid;
    logic        gap;
    logic [10:0] block;
    logic [13:0] ptype;
  } pkt_rec_t;

endpackage

FILE: hdl/gvspft_front.sv
module gvspft_front #(
  parameter int MAX_PACKET_BYTES = gvspft_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       in_packet_infos,
  input  logic [15:0]       in_short_frame_id,
  input  logic [63:0]       in_long_frame_id,
  input  logic [31:0]       in_long_packet_id,
  input  logic [15:0]       in_leader_type_word,
  input  logic [10:0]       in_packet_length,
  input  logic              q_full,
  output logic              q_push,
  output gvspft_pkg::pkt_rec_t q_wdata
);
  import gvspft_pkg::*;

  logic [31:0] prev_id_r, prev_id_nxt;
  logic        ext;
  logic [6:0]  kind;
  logic [31:0] pid;
  logic [4:0]  base_oh;
  logic [10:0] len_c;
  logic [13:0] ptype;
  logic [10:0] block;

  function automatic logic [10:0] net_size(input logic [10:0] len, input logic [4:0] oh);
    logic [10:0] oh_w;
    oh_w = {6'd0, oh};
    return (len > oh_w) ? (len - oh_w) : 11'd0;
  endfunction

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  assign ext     = in_packet_infos[31];
  assign kind    = in_packet_infos[30:24];
  assign pid     = ext ? in_long_packet_id : {8'd0, in_packet_infos[23:0]};
  assign base_oh = ext ? 5'd20 : 5'd8;
  assign ptype   = in_leader_type_word[13:0];
  assign len_c   = ({21'd0, in_packet_length} > 32'(MAX_PACKET_BYTES)) ?
                   11'(MAX_PACKET_BYTES) : in_packet_length;

  always_comb begin
    case (kind)
      KIND_LEADER: begin
        block = (ptype == 14'd1 || ptype == 14'd4 || ptype == 14'd5) ?
                net_size(len_c, base_oh) : 11'd0;
      end
      KIND_PAYLOAD:   block = net_size(len_c, base_oh);
      KIND_MULTIPART: block = net_size(len_c, base_oh + 5'd8);
      default:        block = 11'd0;
    endcase
  end

  always_comb begin
    q_wdata.kind  = kind;
    q_wdata.pid   = pid;
    q_wdata.fid   = ext ? in_long_frame_id : {48'd0, in_short_frame_id};
    q_wdata.gap   = (pid != 32'd0) && ((pid - prev_id_r) != 32'd1);
    q_wdata.block = block;
    q_wdata.ptype = (kind == KIND_LEADER) ? ptype : 14'd0;
  end

  // A trailer closes the id sequence, so the next packet is compared against zero.
  always_comb begin
    prev_id_nxt = prev_id_r;
    if (q_push) begin
      prev_id_nxt = (kind == KIND_TRAILER) ? 32'd0 : pid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_id_r <= 32'd0;
    end else begin
      prev_id_r <= prev_id_nxt;
    end
  end

endmodule

FILE: hdl/gvspft_queue.sv
module gvspft_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  gvspft_pkg::pkt_rec_t wdata,
  output logic                 full,
  input  logic                 pop,
  output logic                 rvalid,
  output gvspft_pkg::pkt_rec_t rdata
);
  import gvspft_pkg::*;

  pkt_rec_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full   = (count_r == (QPTR_W+1)'(QDEPTH));
  assign rvalid = (count_r != '0);
  assign rdata  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == (QPTR_W)'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == (QPTR_W)'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

FILE: hdl/gvspft_back.sv
module gvspft_back #(
  parameter int FRAME_STORE_BYTES = gvspft_pkg::FRAME_STORE_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [10:0]          cfg_wr_data,
  input  logic                 q_rvalid,
  input  gvspft_pkg::pkt_rec_t q_rdata,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [6:0]           out_content_kind,
  output logic [31:0]          out_seq_id,
  output logic [63:0]          out_frame_number,
  output logic                 out_gap_seen,
  output logic [10:0]          out_block_bytes,
  output logic                 out_store_write,
  output logic [21:0]          out_store_offset,
  output logic                 out_store_overflow,
  output logic                 out_frame_start,
  output logic [13:0]          out_payload_kind,
  output logic                 out_frame_done,
  output logic [26:0]          out_frame_bytes
);
  import gvspft_pkg::*;

  `include "gvsp_packet_frame_tracker_core_assert.svh"

  logic [15:0] block_count_r, block_count_nxt;
  logic        store_ready_r, store_ready_nxt;
  logic [10:0] nominal_r;
  logic        out_valid_r, out_valid_nxt;

  logic [6:0]  kind_r;
  logic [31:0] pid_r;
  logic [63:0] fid_r;
  logic        gap_r;
  logic [10:0] block_r;
  logic        wr_r, ovf_r, start_r, done_r;
  logic [21:0] offset_r;
  logic [13:0] ptype_r;
  logic [26:0] fbytes_r;

  logic        is_payload, is_leader, is_trailer;
  logic [10:0] mul_op;
  logic [26:0] prod;
  logic [27:0] end_pos;
  logic        ovf, wr;

  assign is_payload = (q_rdata.kind == KIND_PAYLOAD);
  assign is_leader  = (q_rdata.kind == KIND_LEADER);
  assign is_trailer = (q_rdata.kind == KIND_TRAILER);

  // One multiplier serves both the store offset of a payload block and the
  // frame length at a trailer.
  assign mul_op  = is_payload ? q_rdata.block : nominal_r;
  assign prod    = 27'(block_count_r) * 27'(mul_op);
  assign end_pos = 28'(prod) + 28'(q_rdata.block);
  assign ovf     = is_payload && store_ready_r && (end_pos > 28'(FRAME_STORE_BYTES));
  assign wr      = is_payload && store_ready_r && !ovf;

  assign q_pop = q_rvalid && (!out_valid_r || !out_stall);

  always_comb begin
    block_count_nxt = block_count_r;
    store_ready_nxt = store_ready_r;
    if (q_pop) begin
      if (is_leader) begin
        block_count_nxt = 16'd0;
        store_ready_nxt = 1'b1;
      end else if (wr && block_count_r != 16'hffff) begin
        block_count_nxt = block_count_r + 16'd1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= 16'd0;
      store_ready_r <= 1'b0;
      nominal_r     <= NOMINAL_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      block_count_r <= block_count_nxt;
      store_ready_r <= store_ready_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_wr_en) begin
        nominal_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r   <= q_rdata.kind;
      pid_r    <= q_rdata.pid;
      fid_r    <= q_rdata.fid;
      gap_r    <= q_rdata.gap;
      block_r  <= q_rdata.block;
      wr_r     <= wr;
      ovf_r    <= ovf;
      offset_r <= wr ? prod[21:0] : 22'd0;
      start_r  <= is_leader;
      ptype_r  <= q_rdata.ptype;
      done_r   <= is_trailer;
      fbytes_r <= is_trailer ? prod : 27'd0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_content_kind   = kind_r;
  assign out_seq_id         = pid_r;
  assign out_frame_number   = fid_r;
  assign out_gap_seen       = gap_r;
  assign out_block_bytes    = block_r;
  assign out_store_write    = wr_r;
  assign out_store_offset   = offset_r;
  assign out_store_overflow = ovf_r;
  assign out_frame_start    = start_r;
  assign out_payload_kind   = ptype_r;
  assign out_frame_done     = done_r;
  assign out_frame_bytes    = fbytes_r;

  `GVSPFT_ASSERT_ALWAYS(a_wr_ovf_excl, !(out_valid_r && wr_r && ovf_r), "write and overflow together")
  `GVSPFT_ASSERT_ALWAYS(a_wr_payload, !(out_valid_r && (wr_r || ovf_r)) || (kind_r == KIND_PAYLOAD), "store flag on a non-payload item")
  `GVSPFT_ASSERT_NEXT(a_leader_clears, q_pop && is_leader, (block_count_r == 16'd0) && store_ready_r, "leader did not reset the block count")
  `GVSPFT_ASSERT_NEXT(a_hold_on_stall, out_valid_r && out_stall, out_valid_r && $stable(kind_r) && $stable(pid_r), "stalled result changed")

endmodule

FILE: hdl/gvsp_packet_frame_tracker_core.sv
// Channel   Handshake            Payload
// in_       in_valid / in_stall  infos, short/long frame id, long packet id,
//                                leader type word, packet length
// out_      out_valid/out_stall  kind, ids, gap, block bytes, store write/offset/
//                                overflow, frame start/done, payload kind, frame bytes
// cfg_      cfg_wr_en            cfg_wr_data: nominal block bytes
//
// One item per cycle is sustained while out_stall is low; each accepted item is written
// to a queue entry, then goes through the offset multiply into the output register when
// it is popped.
// The back end's block count loop closes through a single 16x11 multiplier.
// Reset is synchronous and active low; it clears the id, block count and store state.
// A two-entry queue lets the input keep flowing while a result is stalled;
// in_stall rises only when that queue is full.
module gvsp_packet_frame_tracker_core #(
  parameter int FRAME_STORE_BYTES = gvspft_pkg::FRAME_STORE_BYTES_DEF,
  parameter int MAX_PACKET_BYTES  = gvspft_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_packet_infos,
  input  logic [15:0] in_short_frame_id,
  input  logic [63:0] in_long_frame_id,
  input  logic [31:0] in_long_packet_id,
  input  logic [15:0] in_leader_type_word,
  input  logic [10:0] in_packet_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_content_kind,
  output logic [31:0] out_seq_id,
  output logic [63:0] out_frame_number,
  output logic        out_gap_seen,
  output logic [10:0] out_block_bytes,
  output logic        out_store_write,
  output logic [21:0] out_store_offset,
  output logic        out_store_overflow,
  output logic        out_frame_start,
  output logic [13:0] out_payload_kind,
  output logic        out_frame_done,
  output logic [26:0] out_frame_bytes
);
  import gvspft_pkg::*;

  pkt_rec_t q_wdata, q_rdata;
  logic     q_push, q_pop, q_full, q_rvalid;

  gvspft_front #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_packet_infos     (in_packet_infos),
    .in_short_frame_id   (in_short_frame_id),
    .in_long_frame_id    (in_long_frame_id),
    .in_long_packet_id   (in_long_packet_id),
    .in_leader_type_word (in_leader_type_word),
    .in_packet_length    (in_packet_length),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_wdata             (q_wdata)
  );

  gvspft_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_rvalid),
    .rdata  (q_rdata)
  );

  gvspft_back #(.FRAME_STORE_BYTES(FRAME_STORE_BYTES)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .q_rvalid           (q_rvalid),
    .q_rdata            (q_rdata),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_content_kind   (out_content_kind),
    .out_seq_id         (out_seq_id),
    .out_frame_number   (out_frame_number),
    .out_gap_seen       (out_gap_seen),
    .out_block_bytes    (out_block_bytes),
    .out_store_write    (out_store_write),
    .out_store_offset   (out_store_offset),
    .out_store_overflow (out_store_overflow),
    .out_frame_start    (out_frame_start),
    .out_payload_kind   (out_payload_kind),
    .out_frame_done     (out_frame_done),
    .out_frame_bytes    (out_frame_bytes)
  );

endmodule
